// ----- rtl/ring_frame_receiver_forwarder_unit_defines.svh -----
// ============================================================================
// ring frame receiver assertion macros
// shared property forms for the checker
// ============================================================================
`ifndef RING_FRAME_RECEIVER_FORWARDER_UNIT_DEFINES_SVH
`define RING_FRAME_RECEIVER_FORWARDER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RFRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RFRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rfrf_pkg.sv -----
// ============================================================================
// ring frame receiver package
// result kinds, frame constants and the emission item type
// ============================================================================
package rfrf_pkg;

    // result kinds
    localparam logic [1:0] KIND_FWD      = 2'd0;
    localparam logic [1:0] KIND_DLV      = 2'd1;
    localparam logic [1:0] KIND_CHK_DROP = 2'd2;
    localparam logic [1:0] KIND_OVR_DROP = 2'd3;

    // frame constants
    localparam logic [7:0] START_MARK = 8'hAA;
    localparam logic [7:0] BROADCAST  = 8'h00;

    // reset value of the node address register
    localparam logic [6:0] NODE_ADDR_RST = 7'd1;

    // one result on its way from the sequencer to the output register
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       from_mem;
        logic       last;
    } t_item;

endpackage

// ----- rtl/rfrf_rx_if.sv -----
// ============================================================================
// ring byte channel
// one received ring byte per transfer
// ============================================================================
interface rfrf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/rfrf_res_if.sv -----
// ============================================================================
// result channel
// one forwarded byte, delivered byte or drop report per transfer
// ============================================================================
interface rfrf_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] frame_source;
    logic [7:0] frame_dest;
    logic [7:0] payload_length;
    logic       last;

    modport source (output valid, output kind, output data, output frame_source,
                    output frame_dest, output payload_length, output last,
                    input ready);
    modport sink   (input valid, input kind, input data, input frame_source,
                    input frame_dest, input payload_length, input last,
                    output ready);
endinterface

// ----- rtl/rfrf_cfg_if.sv -----
// ============================================================================
// configuration write channel
// carries the node address register
// ============================================================================
interface rfrf_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] node_address;

    modport source (output valid, output node_address, input ready);
    modport sink   (input valid, input node_address, output ready);
endinterface

// ----- rtl/rfrf_ram.sv -----
// ============================================================================
// generic ram
// one write port, one read port with registered read data
// ============================================================================
module rfrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ring_frame_receiver_forwarder_unit.sv -----
// ============================================================================
// ring frame receiver / forwarder
// parses ring frames, checks the xor checksum, forwards or delivers payload
// ============================================================================
//  channel  | direction | payload
//  i_rx     | in        | rx_byte
//  o_res    | out       | kind, data, frame_source, frame_dest, payload_length, last
//  i_cfg    | in        | node_address (always ready)
//
//  the input takes one received byte a cycle while i_rx is not held low; a checksum
//  byte that yields results holds i_rx low until its last result is in the output
//  register, one result a cycle (one payload buffer read a cycle) while o_res does
//  not stall: up to 2*MAX_PAYLOAD+5 results for a frame
//  reset clears parser, sequencer and output valid; the payload buffer is not cleared
//  a stall on o_res holds the output register and, behind it, the sequencer
module ring_frame_receiver_forwarder_unit #(
    parameter int MAX_PAYLOAD = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    rfrf_rx_if.sink    i_rx,
    rfrf_res_if.source o_res,
    rfrf_cfg_if.sink   i_cfg
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int IW = (CW > 2) ? CW : 2;

    // parser phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SRC  = 3'd1;
    localparam logic [2:0] PH_DST  = 3'd2;
    localparam logic [2:0] PH_SIZE = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CHK  = 3'd5;

    // sequencer sections
    localparam logic [2:0] GEN_HDR  = 3'd0;
    localparam logic [2:0] GEN_FPAY = 3'd1;
    localparam logic [2:0] GEN_CHK  = 3'd2;
    localparam logic [2:0] GEN_DPAY = 3'd3;
    localparam logic [2:0] GEN_DROP = 3'd4;

    // parser state
    logic [6:0]    r_node, n_node;
    logic [2:0]    r_phase, n_phase;
    logic [7:0]    r_src, n_src;
    logic [7:0]    r_dst, n_dst;
    logic [7:0]    r_size, n_size;
    logic [7:0]    r_remain, n_remain;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_pos, n_pos;

    // sequencer state
    logic          r_gen_act, n_gen_act;
    logic [2:0]    r_gen_sec, n_gen_sec;
    logic [IW-1:0] r_gen_idx, n_gen_idx;
    logic          r_dlv, n_dlv;
    logic [CW-1:0] r_npay, n_npay;
    logic [7:0]    r_chk, n_chk;
    logic [1:0]    r_drop, n_drop;

    // read stage and output register
    logic            r_s1_valid, n_s1_valid;
    rfrf_pkg::t_item r_s1, n_s1;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_kind, n_out_kind;
    logic [7:0]      r_out_data, n_out_data;
    logic [7:0]      r_out_src, n_out_src;
    logic [7:0]      r_out_dst, n_out_dst;
    logic [7:0]      r_out_len, n_out_len;
    logic            r_out_last, n_out_last;

    logic            rx_fire;
    logic            busy;
    logic            ram_we;
    logic            ram_re;
    logic [7:0]      ram_rdata;
    logic            out_free;
    logic            s1_move;
    logic            s1_load;
    rfrf_pkg::t_item gen_item;
    logic [AW-1:0]   gen_addr;
    logic [IW-1:0]   npay_last;
    logic            frame_fwd;
    logic            frame_dlv;
    logic [CW-1:0]   frame_npay;

    // input is held off while a frame's results are being produced
    assign busy        = r_gen_act || r_s1_valid;
    assign i_rx.ready  = !busy;
    assign rx_fire     = i_rx.valid && !busy;
    assign i_cfg.ready = 1'b1;

    // frame decisions at the checksum byte
    assign frame_fwd  = (r_src != {1'b0, r_node}) && (r_dst != {1'b0, r_node});
    assign frame_dlv  = (r_dst == rfrf_pkg::BROADCAST) || (r_dst == {1'b0, r_node});
    assign frame_npay = (r_size > 8'(MAX_PAYLOAD)) ? CW'(MAX_PAYLOAD) : CW'(r_size);

    // payload store: written while receiving, read only while input is held off
    assign ram_we = rx_fire && (r_phase == PH_DATA) && (r_pos < 8'(MAX_PAYLOAD));

    rfrf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (i_rx.rx_byte),
        .i_re    (ram_re),
        .i_raddr (gen_addr),
        .o_rdata (ram_rdata)
    );

    // parser and frame end decision
    always_comb begin
        n_node   = r_node;
        n_phase  = r_phase;
        n_src    = r_src;
        n_dst    = r_dst;
        n_size   = r_size;
        n_remain = r_remain;
        n_xor    = r_xor;
        n_pos    = r_pos;
        n_dlv    = r_dlv;
        n_npay   = r_npay;
        n_chk    = r_chk;
        n_drop   = r_drop;
        if (i_cfg.valid) begin
            n_node = i_cfg.node_address;
        end
        if (rx_fire) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_rx.rx_byte == rfrf_pkg::START_MARK) begin
                        n_phase = PH_SRC;
                        n_xor   = 8'd0;
                    end
                end
                PH_SRC: begin
                    n_src   = i_rx.rx_byte;
                    n_xor   = r_xor ^ i_rx.rx_byte;
                    n_phase = PH_DST;
                end
                PH_DST: begin
                    n_dst   = i_rx.rx_byte;
                    n_xor   = r_xor ^ i_rx.rx_byte;
                    n_phase = PH_SIZE;
                end
                PH_SIZE: begin
                    n_size   = i_rx.rx_byte;
                    n_remain = i_rx.rx_byte;
                    n_xor    = r_xor ^ i_rx.rx_byte;
                    n_pos    = 8'd0;
                    n_phase  = (i_rx.rx_byte == 8'd0) ? PH_CHK : PH_DATA;
                end
                PH_DATA: begin
                    n_xor    = r_xor ^ i_rx.rx_byte;
                    n_remain = r_remain - 8'd1;
                    n_pos    = r_pos + 8'd1;
                    if (r_remain == 8'd1) begin
                        n_phase = PH_CHK;
                    end
                end
                PH_CHK: begin
                    n_phase = PH_IDLE;
                    n_chk   = i_rx.rx_byte;
                    n_dlv   = frame_dlv;
                    n_npay  = frame_npay;
                    if (r_size > 8'(MAX_PAYLOAD)) begin
                        n_drop = rfrf_pkg::KIND_OVR_DROP;
                    end else begin
                        n_drop = rfrf_pkg::KIND_CHK_DROP;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // result sequencer: picks the next result and where it comes from
    assign npay_last = IW'(r_npay) - IW'(1);
    assign gen_addr  = r_gen_idx[AW-1:0];

    always_comb begin
        gen_item  = '0;
        n_gen_act = r_gen_act;
        n_gen_sec = r_gen_sec;
        n_gen_idx = r_gen_idx;
        case (r_gen_sec)
            GEN_HDR: begin
                gen_item.kind = rfrf_pkg::KIND_FWD;
                case (r_gen_idx[1:0])
                    2'd0:    gen_item.data = rfrf_pkg::START_MARK;
                    2'd1:    gen_item.data = r_src;
                    2'd2:    gen_item.data = r_dst;
                    default: gen_item.data = r_size;
                endcase
            end
            GEN_FPAY: begin
                gen_item.kind     = rfrf_pkg::KIND_FWD;
                gen_item.from_mem = 1'b1;
            end
            GEN_CHK: begin
                gen_item.kind = rfrf_pkg::KIND_FWD;
                gen_item.data = r_chk;
                gen_item.last = !(r_dlv && (r_npay != '0));
            end
            GEN_DPAY: begin
                gen_item.kind     = rfrf_pkg::KIND_DLV;
                gen_item.from_mem = 1'b1;
                gen_item.last     = (r_gen_idx == npay_last);
            end
            default: begin
                gen_item.kind = r_drop;
                gen_item.last = 1'b1;
            end
        endcase

        // step to the next result once this one enters the read stage
        if (s1_load) begin
            case (r_gen_sec)
                GEN_HDR: begin
                    if (r_gen_idx[1:0] == 2'd3) begin
                        n_gen_idx = '0;
                        n_gen_sec = (r_npay != '0) ? GEN_FPAY : GEN_CHK;
                    end else begin
                        n_gen_idx = r_gen_idx + IW'(1);
                    end
                end
                GEN_FPAY: begin
                    if (r_gen_idx == npay_last) begin
                        n_gen_idx = '0;
                        n_gen_sec = GEN_CHK;
                    end else begin
                        n_gen_idx = r_gen_idx + IW'(1);
                    end
                end
                GEN_CHK: begin
                    n_gen_idx = '0;
                    n_gen_sec = GEN_DPAY;
                    n_gen_act = !gen_item.last;
                end
                GEN_DPAY: begin
                    n_gen_idx = r_gen_idx + IW'(1);
                    n_gen_act = !gen_item.last;
                end
                default: begin
                    n_gen_act = 1'b0;
                end
            endcase
        end

        // a checksum byte starts the sequence for its frame
        if (rx_fire && (r_phase == PH_CHK)) begin
            n_gen_idx = '0;
            if (r_size > 8'(MAX_PAYLOAD) || i_rx.rx_byte != r_xor) begin
                n_gen_act = 1'b1;
                n_gen_sec = GEN_DROP;
            end else if (frame_fwd) begin
                n_gen_act = 1'b1;
                n_gen_sec = GEN_HDR;
            end else if (frame_dlv && (frame_npay != '0)) begin
                n_gen_act = 1'b1;
                n_gen_sec = GEN_DPAY;
            end else begin
                n_gen_act = 1'b0;
            end
        end
    end

    // read stage and output register handshake
    assign out_free = !r_out_valid || o_res.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_load  = r_gen_act && (!r_s1_valid || s1_move);
    assign ram_re   = s1_load && gen_item.from_mem;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1        = r_s1;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_src   = r_out_src;
        n_out_dst   = r_out_dst;
        n_out_len   = r_out_len;
        n_out_last  = r_out_last;
        if (s1_move) begin
            n_s1_valid  = 1'b0;
            n_out_valid = 1'b1;
            n_out_kind  = r_s1.kind;
            n_out_data  = r_s1.from_mem ? ram_rdata : r_s1.data;
            n_out_src   = r_src;
            n_out_dst   = r_dst;
            n_out_len   = r_size;
            n_out_last  = r_s1.last;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (s1_load) begin
            n_s1_valid = 1'b1;
            n_s1       = gen_item;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node      <= rfrf_pkg::NODE_ADDR_RST;
            r_phase     <= PH_IDLE;
            r_src       <= 8'd0;
            r_dst       <= 8'd0;
            r_size      <= 8'd0;
            r_remain    <= 8'd0;
            r_xor       <= 8'd0;
            r_gen_act   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_node      <= n_node;
            r_phase     <= n_phase;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_size      <= n_size;
            r_remain    <= n_remain;
            r_xor       <= n_xor;
            r_gen_act   <= n_gen_act;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_gen_sec  <= n_gen_sec;
        r_gen_idx  <= n_gen_idx;
        r_dlv      <= n_dlv;
        r_npay     <= n_npay;
        r_chk      <= n_chk;
        r_drop     <= n_drop;
        r_s1       <= n_s1;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_src  <= n_out_src;
        r_out_dst  <= n_out_dst;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    // result port
    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out_kind;
    assign o_res.data           = r_out_data;
    assign o_res.frame_source   = r_out_src;
    assign o_res.frame_dest     = r_out_dst;
    assign o_res.payload_length = r_out_len;
    assign o_res.last           = r_out_last;

endmodule

// ----- rtl/rfrf_checker.sv -----
// ============================================================================
// ring frame receiver checker
// port-level properties, bound to the top level
// ============================================================================
`include "ring_frame_receiver_forwarder_unit_defines.svh"

module rfrf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_res_kind,
    input logic [7:0] i_res_data,
    input logic [7:0] i_res_src,
    input logic       i_res_last
);

    // a stalled result holds
    `RFRF_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_data) && $stable(i_res_kind), "stalled result changed")

    // input stays held off while a frame still has results to come
    `RFRF_ASSERT_NOW(a_rx_blocked, i_clk, i_rst_n, i_res_valid && !i_res_last, !i_rx_ready, "input taken mid-frame")

    // drop reports are single results with zero data
    `RFRF_ASSERT_NOW(a_drop_form, i_clk, i_rst_n, i_res_valid && (i_res_kind == rfrf_pkg::KIND_CHK_DROP || i_res_kind == rfrf_pkg::KIND_OVR_DROP), i_res_last && (i_res_data == 8'd0), "bad drop report")

    // results of one frame share their source address
    `RFRF_ASSERT_NEXT(a_same_frame, i_clk, i_rst_n, i_res_valid && i_res_ready && !i_res_last, !i_res_valid || $stable(i_res_src), "source changed within frame")

endmodule

bind ring_frame_receiver_forwarder_unit rfrf_checker u_rfrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.kind),
    .i_res_data  (o_res.data),
    .i_res_src   (o_res.frame_source),
    .i_res_last  (o_res.last)
);
